FILE: rtl/clx_pkg.sv
// ----------------------------------------------------------------------------
// clx_pkg - shared types and constants of the c subset lexer
// Token kinds, lexer modes, keyword tracking and the token word carried from
// the front end through the queue to the output stage.
// ----------------------------------------------------------------------------
package clx_pkg;

    // longest lexeme counted before the length holds
    localparam int MAX_LEXEME  = 63;
    // width of the byte position counter
    localparam int POS_BITS    = 16;
    // width of the pending length counter
    localparam int LEN_W       = $clog2(MAX_LEXEME + 1);
    // reported token length limit and field widths
    localparam int TOK_LEN_MAX = 63;
    localparam int TOK_LEN_W   = 6;
    localparam int TOK_START_W = 16;
    // queue between front end and output stage
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    typedef enum logic [4:0] {
        K_INT    = 5'd0,
        K_WHILE  = 5'd1,
        K_IDENT  = 5'd2,
        K_NUM    = 5'd3,
        K_ASSIGN = 5'd4,
        K_LE     = 5'd5,
        K_GE     = 5'd6,
        K_EQ     = 5'd7,
        K_NE     = 5'd8,
        K_LT     = 5'd9,
        K_GT     = 5'd10,
        K_PLUS   = 5'd11,
        K_MINUS  = 5'd12,
        K_MUL    = 5'd13,
        K_DIV    = 5'd14,
        K_SEMI   = 5'd15,
        K_LBRACE = 5'd16,
        K_RBRACE = 5'd17,
        K_LPAREN = 5'd18,
        K_RPAREN = 5'd19,
        K_EOF    = 5'd20,
        K_ERROR  = 5'd21
    } t_kind;

    typedef enum logic [2:0] {
        M_IDLE,
        M_IDENT,
        M_NUM,
        M_LT,
        M_GT,
        M_EQ,
        M_BANG
    } t_mode;

    typedef enum logic [1:0] {
        TRK_NONE,
        TRK_INT,
        TRK_WHILE
    } t_track;

    typedef struct packed {
        t_kind                  kind;
        logic [TOK_START_W-1:0] start;
        logic [TOK_LEN_W-1:0]   length;
        logic                   last;
    } t_token;

    // front end to queue: number of words pushed and the words themselves
    typedef struct packed {
        logic [1:0] n;
        t_token     slot0;
        t_token     slot1;
    } t_push;

    // queue head as seen by the output stage
    typedef struct packed {
        logic   valid;
        t_token tok;
    } t_qhead;

    // limit a pending length to the reported field width
    function automatic logic [TOK_LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
        logic [TOK_LEN_W-1:0] res;
        begin
            if (32'(len) > 32'(TOK_LEN_MAX)) begin
                res = TOK_LEN_W'(TOK_LEN_MAX);
            end else begin
                res = TOK_LEN_W'(len);
            end
            return res;
        end
    endfunction

endpackage

FILE: rtl/c_subset_lexer_core.sv
// ----------------------------------------------------------------------------
// c_subset_lexer_core - streaming lexer for a small c subset
// Input channel: one source byte per word on i_in_byte with i_in_valid and
// o_in_ready; a zero byte ends the stream with an eof token and restarts the
// position count at zero.
// Output channel: one token per word (kind, start position, length and a
// last-of-byte flag) on o_out_valid and i_out_ready.
// Throughput: one byte per cycle while the queue has room; a byte that closes
// a token and makes one of its own pushes two words, and the output stage
// drains one word a cycle while the receiver is ready, so sustained rate
// follows the token count, one output word per cycle.
// A token reaches the outputs through a queue write, then the output register.
// A four-word queue parts the front end from the output register; the front
// end takes bytes while the queue has room for two words, so a stalled
// receiver stops input once three or four words wait behind the output.
// Reset (synchronous, active low) empties the queue and output and puts the
// lexer back between tokens at position zero.
// ----------------------------------------------------------------------------
module c_subset_lexer_core
    import clx_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [4:0] o_token_kind,
    output logic [15:0] o_token_start,
    output logic [5:0] o_token_length,
    output logic       o_last_of_step
);

    t_push  push;
    t_qhead head;
    t_token tok;
    logic   room;
    logic   pop;

    // front end: classify bytes, track pending token
    clx_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_byte  (i_in_byte),
        .i_room     (room),
        .o_in_ready (o_in_ready),
        .o_push     (push)
    );

    // token queue
    clx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_room  (room),
        .o_head  (head)
    );

    // output register
    clx_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_out_ready (i_out_ready),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_tok       (tok)
    );

    assign o_token_kind   = tok.kind;
    assign o_token_start  = tok.start;
    assign o_token_length = tok.length;
    assign o_last_of_step = tok.last;

endmodule

FILE: rtl/clx_front.sv
// ----------------------------------------------------------------------------
// clx_front - lexer front end
// Accepts one source byte per cycle while the queue has room, classifies it,
// advances maximal munch and pushes zero, one or two token words to the queue.
// ----------------------------------------------------------------------------
module clx_front
    import clx_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [7:0] i_in_byte,
    input  logic       i_room,
    output logic       o_in_ready,
    output t_push      o_push
);

    // character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UZ     = 8'h5A;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LZ     = 8'h7A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_H      = 8'h68;
    localparam logic [7:0] CH_I      = 8'h69;
    localparam logic [7:0] CH_L      = 8'h6C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_W      = 8'h77;

    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    // does byte c keep the keyword prefix alive at index idx
    function automatic logic kw_match(input t_track trk, input logic [LEN_W-1:0] idx,
                                      input logic [7:0] c);
        logic hit;
        begin
            hit = 1'b0;
            case (trk)
                TRK_INT: begin
                    if (idx == LEN_W'(0)) hit = (c == CH_I);
                    else if (idx == LEN_W'(1)) hit = (c == CH_N);
                    else if (idx == LEN_W'(2)) hit = (c == CH_T);
                end
                TRK_WHILE: begin
                    if (idx == LEN_W'(0)) hit = (c == CH_W);
                    else if (idx == LEN_W'(1)) hit = (c == CH_H);
                    else if (idx == LEN_W'(2)) hit = (c == CH_I);
                    else if (idx == LEN_W'(3)) hit = (c == CH_L);
                    else if (idx == LEN_W'(4)) hit = (c == CH_E);
                end
                default: hit = 1'b0;
            endcase
            return hit;
        end
    endfunction

    t_mode               r_mode, n_mode;
    t_track              r_track, n_track;
    logic [POS_BITS-1:0] r_pstart, n_pstart;
    logic [LEN_W-1:0]    r_plen, n_plen;
    logic [POS_BITS-1:0] r_pos, n_pos;

    logic   accept;
    logic   is_alpha, is_digit, is_space, is_id;
    logic   handled, ended;
    logic   t0_v, t1_v;
    t_token t0, t1;

    assign o_in_ready = i_room;
    assign accept     = i_in_valid & i_room;

    // byte classes
    always_comb begin
        is_alpha = ((i_in_byte >= CH_LA) && (i_in_byte <= CH_LZ)) ||
                   ((i_in_byte >= CH_UA) && (i_in_byte <= CH_UZ));
        is_digit = (i_in_byte >= CH_0) && (i_in_byte <= CH_9);
        is_space = (i_in_byte == CH_SPACE) ||
                   ((i_in_byte >= CH_TAB) && (i_in_byte <= CH_CR));
        is_id    = is_alpha | is_digit | (i_in_byte == CH_UNDER);
    end

    // lexer step: close the pending token, then handle the byte from idle
    always_comb begin
        n_mode   = r_mode;
        n_track  = r_track;
        n_pstart = r_pstart;
        n_plen   = r_plen;
        handled  = 1'b0;
        ended    = 1'b0;
        t0_v     = 1'b0;
        t1_v     = 1'b0;
        t0       = '{kind: K_ERROR, start: TOK_START_W'(r_pstart), length: '0, last: 1'b0};
        t1       = '{kind: K_ERROR, start: TOK_START_W'(r_pos), length: '0, last: 1'b1};

        unique case (r_mode)
            M_IDENT: begin
                if (is_id) begin
                    handled = 1'b1;
                    if (!kw_match(r_track, r_plen, i_in_byte)) n_track = TRK_NONE;
                    if (r_plen < LEN_W'(MAX_LEXEME)) n_plen = r_plen + LEN_W'(1);
                end else begin
                    t0_v      = 1'b1;
                    t0.length = sat_len(r_plen);
                    if (r_track == TRK_INT && r_plen == LEN_W'(3)) t0.kind = K_INT;
                    else if (r_track == TRK_WHILE && r_plen == LEN_W'(5)) t0.kind = K_WHILE;
                    else t0.kind = K_IDENT;
                end
            end
            M_NUM: begin
                if (is_digit) begin
                    handled = 1'b1;
                    if (r_plen < LEN_W'(MAX_LEXEME)) n_plen = r_plen + LEN_W'(1);
                end else begin
                    t0_v      = 1'b1;
                    t0.kind   = K_NUM;
                    t0.length = sat_len(r_plen);
                end
            end
            M_LT, M_GT, M_EQ, M_BANG: begin
                t0_v = 1'b1;
                if (i_in_byte == CH_EQ) begin
                    handled   = 1'b1;
                    t0.length = TOK_LEN_W'(2);
                    unique case (r_mode)
                        M_LT:    t0.kind = K_LE;
                        M_GT:    t0.kind = K_GE;
                        M_EQ:    t0.kind = K_EQ;
                        default: t0.kind = K_NE;
                    endcase
                end else begin
                    t0.length = TOK_LEN_W'(1);
                    unique case (r_mode)
                        M_LT:    t0.kind = K_LT;
                        M_GT:    t0.kind = K_GT;
                        M_EQ:    t0.kind = K_ASSIGN;
                        default: t0.kind = K_ERROR;
                    endcase
                end
                n_mode  = M_IDLE;
                n_track = TRK_NONE;
                n_plen  = '0;
            end
            default: begin
            end
        endcase

        // byte not absorbed by the pending token
        if (!handled) begin
            n_mode  = M_IDLE;
            n_track = TRK_NONE;
            n_plen  = '0;
            if (i_in_byte == CH_NUL) begin
                t1_v    = 1'b1;
                t1.kind = K_EOF;
                ended   = 1'b1;
            end else if (is_space) begin
                t1_v = 1'b0;
            end else if (is_alpha || i_in_byte == CH_UNDER) begin
                n_mode   = M_IDENT;
                n_pstart = r_pos;
                n_plen   = LEN_W'(1);
                if (i_in_byte == CH_I) n_track = TRK_INT;
                else if (i_in_byte == CH_W) n_track = TRK_WHILE;
            end else if (is_digit) begin
                n_mode   = M_NUM;
                n_pstart = r_pos;
                n_plen   = LEN_W'(1);
            end else begin
                unique case (i_in_byte)
                    CH_LT, CH_GT, CH_EQ, CH_BANG: begin
                        n_pstart = r_pos;
                        n_plen   = LEN_W'(1);
                        unique case (i_in_byte)
                            CH_LT:   n_mode = M_LT;
                            CH_GT:   n_mode = M_GT;
                            CH_EQ:   n_mode = M_EQ;
                            default: n_mode = M_BANG;
                        endcase
                    end
                    default: begin
                        t1_v      = 1'b1;
                        t1.length = TOK_LEN_W'(1);
                        unique case (i_in_byte)
                            CH_PLUS:   t1.kind = K_PLUS;
                            CH_MINUS:  t1.kind = K_MINUS;
                            CH_STAR:   t1.kind = K_MUL;
                            CH_SLASH:  t1.kind = K_DIV;
                            CH_SEMI:   t1.kind = K_SEMI;
                            CH_LBRACE: t1.kind = K_LBRACE;
                            CH_RBRACE: t1.kind = K_RBRACE;
                            CH_LPAREN: t1.kind = K_LPAREN;
                            CH_RPAREN: t1.kind = K_RPAREN;
                            default:   t1.kind = K_ERROR;
                        endcase
                    end
                endcase
            end
        end

        // position and end-of-stream clear
        if (ended) begin
            n_mode   = M_IDLE;
            n_track  = TRK_NONE;
            n_pstart = '0;
            n_plen   = '0;
            n_pos    = '0;
        end else if (r_pos != POS_MAX) begin
            n_pos = r_pos + POS_BITS'(1);
        end else begin
            n_pos = r_pos;
        end
    end

    // pack up to two words, last flag on the final one
    always_comb begin
        o_push.slot1 = t1;
        if (t0_v && t1_v) begin
            o_push.n     = 2'd2;
            o_push.slot0 = t0;
        end else if (t0_v) begin
            o_push.n          = 2'd1;
            o_push.slot0      = t0;
            o_push.slot0.last = 1'b1;
        end else begin
            o_push.n     = t1_v ? 2'd1 : 2'd0;
            o_push.slot0 = t1;
        end
        if (!accept) o_push.n = 2'd0;
    end

    // lexer state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_track  <= TRK_NONE;
            r_pstart <= '0;
            r_plen   <= '0;
            r_pos    <= '0;
        end else if (accept) begin
            r_mode   <= n_mode;
            r_track  <= n_track;
            r_pstart <= n_pstart;
            r_plen   <= n_plen;
            r_pos    <= n_pos;
        end
    end

endmodule

FILE: rtl/clx_queue.sv
// ----------------------------------------------------------------------------
// clx_queue - token queue between front end and output stage
// Takes up to two words per cycle, gives one per cycle when popped, and
// signals room for a full two-word push so the front end can run on its own.
// ----------------------------------------------------------------------------
module clx_queue
    import clx_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_push  i_push,
    input  logic   i_pop,
    output logic   o_room,
    output t_qhead o_head
);

    t_token             r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, n_wr;
    logic [Q_PTR_W-1:0] r_rd, n_rd;
    logic [Q_CNT_W-1:0] r_count, n_count;
    logic [Q_PTR_W-1:0] wr_next;

    assign wr_next     = r_wr + Q_PTR_W'(1);
    assign o_room      = (r_count <= Q_CNT_W'(Q_DEPTH - 2));
    assign o_head.valid = (r_count != '0);
    assign o_head.tok  = r_mem[r_rd];

    // pointer and fill arithmetic
    always_comb begin
        n_wr    = r_wr + Q_PTR_W'(i_push.n);
        n_rd    = i_pop ? r_rd + Q_PTR_W'(1) : r_rd;
        n_count = r_count + Q_CNT_W'(i_push.n) - Q_CNT_W'(i_pop);
    end

    // storage writes
    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) r_mem[r_wr] <= i_push.slot0;
        if (i_push.n == 2'd2) r_mem[wr_next] <= i_push.slot1;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // a push never overruns the free space
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_count) + 32'(i_push.n)) <= (Q_DEPTH + 32'(i_pop)))
        else $error("queue overflow");

    // a pop only from a non-empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue underflow");

    // fill count follows the pointers
    a_count_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != Q_CNT_W'(Q_DEPTH)) |-> (Q_PTR_W'(r_count) == Q_PTR_W'(r_wr - r_rd)))
        else $error("queue count and pointers disagree");

endmodule

FILE: rtl/clx_emit.sv
// ----------------------------------------------------------------------------
// clx_emit - output stage
// Holds one token word in the output register and refills it from the queue
// head, if it holds a word, whenever the register is empty or being taken.
// ----------------------------------------------------------------------------
module clx_emit
    import clx_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_qhead i_head,
    input  logic   i_out_ready,
    output logic   o_pop,
    output logic   o_out_valid,
    output t_token o_tok
);

    logic   r_valid;
    t_token r_tok;

    assign o_pop       = i_head.valid & (~r_valid | i_out_ready);
    assign o_out_valid = r_valid;
    assign o_tok       = r_tok;

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (o_pop) r_tok <= i_head.tok;
    end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - testbench of the c subset lexer core
// Feeds source bytes through the valid/ready input channel and predicts every
// token word in the testbench's own lexer model. Each word taken from the
// output channel is checked field by field against the oldest prediction.
// A directed sequence covers each token kind and the odd cases, then random
// token streams follow under three idling mixes.
// ----------------------------------------------------------------------------
module tb_top
    import clx_pkg::*;
();

    localparam int         CYCLE_LIMIT  = 1_000_000;
    localparam int         DRAIN_CYCLES = 20;
    localparam int         PRINT_LIMIT  = 40;
    localparam logic [7:0] END_BYTE     = 8'h00;
    localparam logic [15:0] POS_TOP     = 16'hFFFF;

    logic       i_clk;
    logic       i_rst_n     = 1'b0;
    logic       in_valid    = 1'b0;
    logic [7:0] in_byte     = 8'h00;
    logic       out_ready   = 1'b0;
    wire        in_ready;
    wire        out_valid;
    wire [4:0]  out_kind;
    wire [15:0] out_start;
    wire [5:0]  out_length;
    wire        out_last;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int error_count   = 0;
    int cycle_count   = 0;
    int sent_count    = 0;

    // lexer model state
    t_mode              cur_mode   = M_IDLE;
    t_track             cur_track  = TRK_NONE;
    logic [15:0]        pend_start = '0;
    logic [LEN_W-1:0]   pend_len   = '0;
    logic [15:0]        cur_pos    = '0;

    // predicted token words, oldest first
    t_token expected_tokens[$];

    c_subset_lexer_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_in_byte      (in_byte),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_token_kind   (out_kind),
        .o_token_start  (out_start),
        .o_token_length (out_length),
        .o_last_of_step (out_last)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver stalls
    always @(negedge i_clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT) begin
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        end
    endtask

    // ------------------------------------------------------------------------
    // lexer model
    // ------------------------------------------------------------------------
    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic t_token make_tok(input t_kind kind, input logic [15:0] start,
                                        input int len);
        t_token t;
        t.kind   = kind;
        t.start  = start;
        t.length = (len > TOK_LEN_MAX) ? TOK_LEN_W'(TOK_LEN_MAX) : TOK_LEN_W'(len);
        t.last   = 1'b0;
        return t;
    endfunction

    function automatic t_kind ident_kind();
        if (cur_track == TRK_INT && pend_len == 3) return K_INT;
        if (cur_track == TRK_WHILE && pend_len == 5) return K_WHILE;
        return K_IDENT;
    endfunction

    // drop keyword tracking once the identifier leaves the keyword's spelling
    function automatic void track_step(input logic [7:0] c);
        string word_int;
        string word_while;
        word_int   = "int";
        word_while = "while";
        if (cur_track == TRK_INT) begin
            if (!(pend_len < 3 && word_int[pend_len] == c)) cur_track = TRK_NONE;
        end else if (cur_track == TRK_WHILE) begin
            if (!(pend_len < 5 && word_while[pend_len] == c)) cur_track = TRK_NONE;
        end
    endfunction

    function automatic void open_token(input t_mode mode, input logic [15:0] p);
        cur_mode   = mode;
        pend_start = p;
        pend_len   = LEN_W'(1);
        cur_track  = TRK_NONE;
    endfunction

    // advance the model by one accepted byte and queue the words it causes
    function automatic void lex_byte(input logic [7:0] c);
        t_token      toks[2];
        int          n;
        logic        handled;
        logic        ended;
        logic [15:0] p;
        n       = 0;
        handled = 1'b0;
        ended   = 1'b0;
        p       = cur_pos;

        // close or extend the pending token
        case (cur_mode)
            M_IDENT: begin
                if (is_letter(c) || is_digit(c) || c == "_") begin
                    track_step(c);
                    if (pend_len < MAX_LEXEME) pend_len++;
                    handled = 1'b1;
                end else begin
                    toks[n] = make_tok(ident_kind(), pend_start, int'(pend_len));
                    n++;
                end
            end
            M_NUM: begin
                if (is_digit(c)) begin
                    if (pend_len < MAX_LEXEME) pend_len++;
                    handled = 1'b1;
                end else begin
                    toks[n] = make_tok(K_NUM, pend_start, int'(pend_len));
                    n++;
                end
            end
            M_LT, M_GT, M_EQ, M_BANG: begin
                if (c == "=") begin
                    toks[n] = make_tok(cur_mode == M_LT ? K_LE :
                                       cur_mode == M_GT ? K_GE :
                                       cur_mode == M_EQ ? K_EQ : K_NE, pend_start, 2);
                    handled = 1'b1;
                end else begin
                    toks[n] = make_tok(cur_mode == M_LT ? K_LT :
                                       cur_mode == M_GT ? K_GT :
                                       cur_mode == M_EQ ? K_ASSIGN : K_ERROR,
                                       pend_start, 1);
                end
                n++;
                cur_mode  = M_IDLE;
                cur_track = TRK_NONE;
                pend_len  = '0;
            end
            default: ;
        endcase

        // the byte starts something of its own
        if (!handled) begin
            cur_mode  = M_IDLE;
            cur_track = TRK_NONE;
            pend_len  = '0;
            if (c == END_BYTE) begin
                toks[n] = make_tok(K_EOF, p, 0);
                n++;
                ended = 1'b1;
            end else if (is_blank(c)) begin
            end else if (is_letter(c) || c == "_") begin
                open_token(M_IDENT, p);
                cur_track = (c == "i") ? TRK_INT : (c == "w") ? TRK_WHILE : TRK_NONE;
            end else if (is_digit(c)) begin
                open_token(M_NUM, p);
            end else begin
                case (c)
                    "<": open_token(M_LT, p);
                    ">": open_token(M_GT, p);
                    "=": open_token(M_EQ, p);
                    "!": open_token(M_BANG, p);
                    "+": begin toks[n] = make_tok(K_PLUS, p, 1);   n++; end
                    "-": begin toks[n] = make_tok(K_MINUS, p, 1);  n++; end
                    "*": begin toks[n] = make_tok(K_MUL, p, 1);    n++; end
                    "/": begin toks[n] = make_tok(K_DIV, p, 1);    n++; end
                    ";": begin toks[n] = make_tok(K_SEMI, p, 1);   n++; end
                    "{": begin toks[n] = make_tok(K_LBRACE, p, 1); n++; end
                    "}": begin toks[n] = make_tok(K_RBRACE, p, 1); n++; end
                    "(": begin toks[n] = make_tok(K_LPAREN, p, 1); n++; end
                    ")": begin toks[n] = make_tok(K_RPAREN, p, 1); n++; end
                    default: begin toks[n] = make_tok(K_ERROR, p, 1); n++; end
                endcase
            end
        end

        // end of input restarts everything, else the position moves on
        if (ended) begin
            cur_mode   = M_IDLE;
            cur_track  = TRK_NONE;
            pend_start = '0;
            pend_len   = '0;
            cur_pos    = '0;
        end else if (cur_pos != POS_TOP) begin
            cur_pos++;
        end

        if (n > 0) toks[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) expected_tokens.push_back(toks[i]);
    endfunction

    // ------------------------------------------------------------------------
    // output check
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_token want;
        if (i_rst_n && out_valid && out_ready) begin
            if (expected_tokens.size() == 0) begin
                report_mismatch($sformatf("unexpected word kind %0d start %0d length %0d",
                                          out_kind, out_start, out_length));
            end else begin
                want = expected_tokens.pop_front();
                if (out_kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, want %0d (start %0d)",
                                              out_kind, want.kind, want.start));
                if (out_start !== want.start)
                    report_mismatch($sformatf("start %0d, want %0d",
                                              out_start, want.start));
                if (out_length !== want.length)
                    report_mismatch($sformatf("length %0d, want %0d (start %0d)",
                                              out_length, want.length, want.start));
                if (out_last !== want.last)
                    report_mismatch($sformatf("last flag %0d, want %0d (start %0d)",
                                              out_last, want.last, want.start));
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    // drive one byte and hold it until the core takes it
    task automatic send_byte(input logic [7:0] b);
        int gap;
        @(negedge i_clk);
        if ($urandom_range(99) < send_idle_pct) begin
            gap = $urandom_range(4, 1);
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        do begin
            @(posedge i_clk);
        end while (!in_ready);
        lex_byte(b);
        sent_count++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    function automatic logic [7:0] pick_blank();
        int r;
        r = $urandom_range(5);
        return (r == 0) ? " " : 8'(8 + r);
    endfunction

    function automatic logic [7:0] pick_word_char(input logic first);
        int r;
        r = first ? $urandom_range(52) : $urandom_range(62);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        if (r == 52) return "_";
        return 8'("0" + r - 53);
    endfunction

    function automatic string near_keyword();
        case ($urandom_range(7))
            0: return "in";
            1: return "inta";
            2: return "whil";
            3: return "whilex";
            4: return "i";
            5: return "w";
            6: return "int_";
            default: return "Int";
        endcase
    endfunction

    // one random lexeme, then maybe a blank; a zero byte only when allowed
    task automatic send_lexeme(input logic allow_end);
        string ops;
        int    r;
        int    len;
        logic [7:0] noise;
        ops = "<=>!+-*/;{}()";
        r   = $urandom_range(99);
        if (r < 10) begin
            if ($urandom_range(1)) send_text("int");
            else send_text("while");
        end else if (r < 18) begin
            send_text(near_keyword());
        end else if (r < 36) begin
            len = ($urandom_range(29) == 0) ? $urandom_range(75, 55) : $urandom_range(8, 1);
            send_byte(pick_word_char(1'b1));
            for (int i = 1; i < len; i++) send_byte(pick_word_char(1'b0));
        end else if (r < 51) begin
            len = ($urandom_range(29) == 0) ? $urandom_range(70, 60) : $urandom_range(6, 1);
            for (int i = 0; i < len; i++) send_byte(8'("0" + $urandom_range(9)));
        end else if (r < 60) begin
            send_byte(ops[$urandom_range(ops.len() - 1)]);
        end else if (r < 69) begin
            case ($urandom_range(3))
                0: send_text("<=");
                1: send_text(">=");
                2: send_text("==");
                default: send_text("!=");
            endcase
        end else if (r < 83) begin
            send_byte(pick_blank());
        end else if (r < 95 || !allow_end) begin
            noise = allow_end ? 8'($urandom_range(255)) : 8'($urandom_range(255, 1));
            send_byte(noise);
        end else begin
            send_byte(END_BYTE);
        end
        if ($urandom_range(1)) send_byte(pick_blank());
    endtask

    // every token kind, lone '!', unknown bytes, end of input
    task automatic test_directed_tokens();
        send_text("int\twhile=<=>===!=!;<>+-*/{}()9a@");
        send_byte(8'hFF);
        send_byte(8'h80);
        send_text("!");
        send_byte(END_BYTE);
    endtask

    task automatic test_random_stream(input int tx_pct, input int rx_pct, input int n_bytes);
        int target;
        send_idle_pct = tx_pct;
        recv_idle_pct = rx_pct;
        target        = sent_count + n_bytes;
        while (sent_count < target) send_lexeme(1'b1);
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 37;
        recv_idle_pct = 62;
        test_directed_tokens();
        test_random_stream(37, 62, 638);
        test_random_stream(62, 37, 638);
        test_random_stream(0, 0, 638);

        @(negedge i_clk);
        in_valid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: c_subset_lexer_core.f
rtl/clx_pkg.sv
rtl/clx_front.sv
rtl/clx_queue.sv
rtl/clx_emit.sv
rtl/c_subset_lexer_core.sv
tb/sv/tb_top.sv
